// ===== rtl/irm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irm_pkg
// Types and constants shared by the register-access bus master.
// ----------------------------------------------------------------------------
package irm_pkg;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_SETUP     = 4'd1;
    localparam logic [3:0] PH_START     = 4'd2;
    localparam logic [3:0] PH_TX_LOW    = 4'd3;
    localparam logic [3:0] PH_TX_HIGH   = 4'd4;
    localparam logic [3:0] PH_ACK_LOW   = 4'd5;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd6;
    localparam logic [3:0] PH_RS_LOW    = 4'd7;
    localparam logic [3:0] PH_RX_LOW    = 4'd8;
    localparam logic [3:0] PH_RX_HIGH   = 4'd9;
    localparam logic [3:0] PH_MACK_LOW  = 4'd10;
    localparam logic [3:0] PH_MACK_HIGH = 4'd11;
    localparam logic [3:0] PH_STOP_LOW  = 4'd12;
    localparam logic [3:0] PH_STOP_HIGH = 4'd13;
    localparam logic [3:0] PH_STOP_REL  = 4'd14;

    localparam logic [1:0] ST_DEV  = 2'd0;
    localparam logic [1:0] ST_REG  = 2'd1;
    localparam logic [1:0] ST_RDEV = 2'd2;
    localparam logic [1:0] ST_DATA = 2'd3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_PROBE = 2'd3;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h48;
    localparam logic [2:0] BIT_MSB        = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] register_address;
        logic [7:0] byte_count_request;
        logic [7:0] write_byte;
        logic [7:0] probe_address;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       data_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic       ack_error;
        logic [7:0] bytes_done;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/irm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irm_if
// Valid/ready channels of the bus master: bus ticks in, tick results out,
// and the device address write channel.
// ----------------------------------------------------------------------------
interface irm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] register_address;
    logic [7:0] byte_count_request;
    logic [7:0] write_byte;
    logic [7:0] probe_address;
    logic       sda_sample;

    modport source (
        output valid, operation, register_address, byte_count_request,
               write_byte, probe_address, sda_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, register_address, byte_count_request,
               write_byte, probe_address, sda_sample,
        output ready
    );
endinterface

interface irm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       data_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic       ack_error;
    logic [7:0] bytes_done;

    modport source (
        output valid, scl_level, sda_pull_low, busy_res, data_taken, read_byte,
               read_valid, done_res, ack_error, bytes_done,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_pull_low, busy_res, data_taken, read_byte,
               read_valid, done_res, ack_error, bytes_done,
        output ready
    );
endinterface

interface irm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;

    modport source (output valid, device_address, input ready);
    modport sink (input valid, device_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/irm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irm_seq
// Bus phase sequencer: holds the transaction state and works out the line
// levels and status of one bus tick.
// ----------------------------------------------------------------------------
module irm_seq
    import irm_pkg::*;
#(
    parameter int TICKS_PER_PHASE = 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_in_item   i_item,
    input  wire logic [7:0] i_device_address,
    output t_out_item       o_result
);

    localparam int TICK_W = (TICKS_PER_PHASE > 1) ? $clog2(TICKS_PER_PHASE) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_PHASE - 1);

    logic [3:0]        r_phase,   n_phase;
    logic [2:0]        r_bit,     n_bit;
    logic [7:0]        r_shift,   n_shift;
    logic [7:0]        r_left,    n_left;
    logic [7:0]        r_counted, n_counted;
    logic [7:0]        r_held,    n_held;
    logic [1:0]        r_kind,    n_kind;
    logic [1:0]        r_stage,   n_stage;
    logic              r_nack,    n_nack;
    logic [TICK_W-1:0] r_tick,    n_tick;
    logic              w_tx_bit;

    always_comb begin
        n_phase   = (r_phase > PH_STOP_REL) ? PH_IDLE : r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_counted = r_counted;
        n_held    = r_held;
        n_kind    = r_kind;
        n_stage   = r_stage;
        n_nack    = r_nack;
        n_tick    = r_tick;
        o_result  = '0;
        o_result.scl_level = 1'b1;

        if (n_phase == PH_IDLE && i_item.operation != OP_TICK) begin
            n_kind    = i_item.operation;
            n_held    = i_item.register_address;
            n_left    = i_item.byte_count_request;
            n_counted = '0;
            n_stage   = ST_DEV;
            n_nack    = 1'b0;
            n_bit     = BIT_MSB;
            n_shift   = (i_item.operation == OP_PROBE) ? i_item.probe_address
                                                       : {i_device_address[7:1], 1'b0};
            n_tick    = '0;
            n_phase   = PH_SETUP;
        end

        w_tx_bit = n_shift[n_bit];

        if (n_phase != PH_IDLE) begin
            o_result.busy_res = 1'b1;
            case (n_phase)
                PH_START: begin
                    o_result.sda_pull_low = 1'b1;
                end
                PH_TX_LOW: begin
                    o_result.scl_level    = 1'b0;
                    o_result.sda_pull_low = !w_tx_bit;
                end
                PH_TX_HIGH: begin
                    o_result.sda_pull_low = !w_tx_bit;
                end
                PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW: begin
                    o_result.scl_level = 1'b0;
                end
                PH_MACK_LOW: begin
                    o_result.scl_level    = 1'b0;
                    o_result.sda_pull_low = (n_left != '0);
                end
                PH_MACK_HIGH: begin
                    o_result.sda_pull_low = (n_left != '0);
                end
                PH_STOP_LOW: begin
                    o_result.scl_level    = 1'b0;
                    o_result.sda_pull_low = 1'b1;
                end
                PH_STOP_HIGH: begin
                    o_result.sda_pull_low = 1'b1;
                end
                default: begin
                end
            endcase

            if (n_tick != TICK_LAST) begin
                n_tick = n_tick + 1'b1;
            end else begin
                n_tick = '0;
                case (n_phase)
                    PH_SETUP:    n_phase = PH_START;
                    PH_START:    n_phase = PH_TX_LOW;
                    PH_TX_LOW:   n_phase = PH_TX_HIGH;
                    PH_TX_HIGH: begin
                        if (n_bit == '0) begin
                            n_phase = PH_ACK_LOW;
                        end else begin
                            n_bit   = n_bit - 1'b1;
                            n_phase = PH_TX_LOW;
                        end
                    end
                    PH_ACK_LOW:  n_phase = PH_ACK_HIGH;
                    PH_ACK_HIGH: begin
                        if (i_item.sda_sample) begin
                            n_nack  = 1'b1;
                            n_phase = PH_STOP_LOW;
                        end else if (n_stage == ST_DEV) begin
                            if (n_kind == OP_PROBE) begin
                                n_phase = PH_STOP_LOW;
                            end else begin
                                n_stage = ST_REG;
                                n_shift = n_held;
                                n_bit   = BIT_MSB;
                                n_phase = PH_TX_LOW;
                            end
                        end else if (n_stage == ST_RDEV) begin
                            if (n_left == '0) begin
                                n_phase = PH_STOP_LOW;
                            end else begin
                                n_stage = ST_DATA;
                                n_shift = '0;
                                n_bit   = BIT_MSB;
                                n_phase = PH_RX_LOW;
                            end
                        end else if (n_stage == ST_REG && n_kind == OP_READ) begin
                            n_stage = ST_RDEV;
                            n_shift = {i_device_address[7:1], 1'b1};
                            n_bit   = BIT_MSB;
                            n_phase = PH_RS_LOW;
                        end else begin
                            if (n_stage == ST_DATA) begin
                                n_counted = n_counted + 1'b1;
                                n_left    = n_left - 1'b1;
                            end
                            if (n_left == '0) begin
                                n_phase = PH_STOP_LOW;
                            end else begin
                                n_stage             = ST_DATA;
                                o_result.data_taken = 1'b1;
                                n_shift             = i_item.write_byte;
                                n_bit               = BIT_MSB;
                                n_phase             = PH_TX_LOW;
                            end
                        end
                    end
                    PH_RS_LOW:   n_phase = PH_SETUP;
                    PH_RX_LOW:   n_phase = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        n_shift = {n_shift[6:0], i_item.sda_sample};
                        if (n_bit == '0) begin
                            o_result.read_byte  = n_shift;
                            o_result.read_valid = 1'b1;
                            n_counted           = n_counted + 1'b1;
                            n_left              = n_left - 1'b1;
                            n_phase             = PH_MACK_LOW;
                        end else begin
                            n_bit   = n_bit - 1'b1;
                            n_phase = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: n_phase = PH_MACK_HIGH;
                    PH_MACK_HIGH: begin
                        if (n_left == '0) begin
                            n_phase = PH_STOP_LOW;
                        end else begin
                            n_shift = '0;
                            n_bit   = BIT_MSB;
                            n_phase = PH_RX_LOW;
                        end
                    end
                    PH_STOP_LOW:  n_phase = PH_STOP_HIGH;
                    PH_STOP_HIGH: n_phase = PH_STOP_REL;
                    default: begin
                        o_result.done_res   = 1'b1;
                        o_result.ack_error  = n_nack;
                        o_result.bytes_done = n_counted;
                        n_phase             = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= '0;
            r_shift   <= '0;
            r_left    <= '0;
            r_counted <= '0;
            r_held    <= '0;
            r_kind    <= '0;
            r_stage   <= ST_DEV;
            r_nack    <= 1'b0;
            r_tick    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_counted <= n_counted;
            r_held    <= n_held;
            r_kind    <= n_kind;
            r_stage   <= n_stage;
            r_nack    <= n_nack;
            r_tick    <= n_tick;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/i2c_register_master_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master_top
// Two-wire bus master for register write, register read and address probe.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one result transfer
// with the clock and data line levels for that tick and the transaction
// status. The block takes one tick per clock cycle unless the result side stalls;
// a tick passes the input register and the phase sequencer into the result
// register. Every bus phase lasts TICKS_PER_PHASE ticks. The device address
// is written through the configuration channel while no tick is in flight;
// the user must keep to this, the block does not enforce it. A change in the
// middle of a transaction affects only later address bytes. It resets to 0x48.
module i2c_register_master_top
    import irm_pkg::*;
#(
    parameter int TICKS_PER_PHASE = 1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    irm_in_if.sink     i_in,
    irm_out_if.source  o_out,
    irm_cfg_if.sink    i_cfg
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic [7:0] r_device_address;
    logic       w_step;
    t_out_item  w_result;

    assign w_step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEV_ADDR_RESET;
        end else if (i_cfg.valid) begin
            r_device_address <= i_cfg.device_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.operation          <= i_in.operation;
            r_in_item.register_address   <= i_in.register_address;
            r_in_item.byte_count_request <= i_in.byte_count_request;
            r_in_item.write_byte         <= i_in.write_byte;
            r_in_item.probe_address      <= i_in.probe_address;
            r_in_item.sda_sample         <= i_in.sda_sample;
        end
    end

    irm_seq #(
        .TICKS_PER_PHASE (TICKS_PER_PHASE)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_item           (r_in_item),
        .i_device_address (r_device_address),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scl_level    = r_out_item.scl_level;
    assign o_out.sda_pull_low = r_out_item.sda_pull_low;
    assign o_out.busy_res     = r_out_item.busy_res;
    assign o_out.data_taken   = r_out_item.data_taken;
    assign o_out.read_byte    = r_out_item.read_byte;
    assign o_out.read_valid   = r_out_item.read_valid;
    assign o_out.done_res     = r_out_item.done_res;
    assign o_out.ack_error    = r_out_item.ack_error;
    assign o_out.bytes_done   = r_out_item.bytes_done;

endmodule
`default_nettype wire

// ===== rtl/irm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irm_port_checks
// Port-level checks of the bus master's result channel.
// ----------------------------------------------------------------------------
module irm_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic       i_scl_level,
    input wire logic       i_sda_pull_low,
    input wire logic       i_busy_res,
    input wire logic       i_data_taken,
    input wire logic       i_read_valid,
    input wire logic       i_done_res,
    input wire logic       i_ack_error,
    input wire logic [7:0] i_bytes_done
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_bytes_done)
                                && $stable(i_scl_level) && $stable(i_done_res))
        else $error("Stalled result changed.");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_done_res || i_ack_error) |-> i_busy_res && i_done_res)
        else $error("Done or acknowledge error outside a transaction end.");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_busy_res |-> i_scl_level && !i_sda_pull_low
                                   && !i_data_taken && !i_read_valid)
        else $error("Lines driven while idle.");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_data_taken && i_read_valid)
                    && !(i_done_res && (i_data_taken || i_read_valid)))
        else $error("Conflicting events in one tick.");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_done_res |-> i_bytes_done == 8'd0)
        else $error("Byte count shown without done.");

endmodule

bind i2c_register_master_top irm_port_checks u_irm_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_scl_level    (o_out.scl_level),
    .i_sda_pull_low (o_out.sda_pull_low),
    .i_busy_res     (o_out.busy_res),
    .i_data_taken   (o_out.data_taken),
    .i_read_valid   (o_out.read_valid),
    .i_done_res     (o_out.done_res),
    .i_ack_error    (o_out.ack_error),
    .i_bytes_done   (o_out.bytes_done)
);
`default_nettype wire

// ===== bench/irm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_checker
// Watches the tick, result and device address channels of the bus master.
// Every accepted tick is run through a cycle-free model of the phase
// sequencer, and the resulting line levels and status are queued. Each
// accepted result transfer is compared field by field with the oldest
// queued expectation. The mismatch count and the number of expectations
// still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module irm_checker
    import irm_pkg::*;
#(
    parameter int TICKS_PER_PHASE = 1
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    irm_in_if         i_tick,
    irm_out_if        i_res,
    irm_cfg_if        i_cfg,
    output int        o_mismatches,
    output int        o_pending
);

    logic [7:0]  dev_addr;
    logic [3:0]  phase;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  bytes_left;
    logic [7:0]  bytes_counted;
    logic [7:0]  held_reg;
    logic [1:0]  kind;
    logic [1:0]  stage;
    logic        nack_seen;
    int unsigned phase_ticks;

    t_out_item   bus_levels_q[$];
    int          mismatch_count = 0;
    int          result_no = 0;

    assign o_mismatches = mismatch_count;

    function automatic void load_byte(input logic [7:0] value);
        shreg   = value;
        bit_idx = BIT_MSB;
        phase   = PH_TX_LOW;
    endfunction

    function automatic logic next_data_or_stop(input logic [7:0] wbyte);
        if (bytes_left == 8'd0) begin
            phase = PH_STOP_LOW;
            return 1'b0;
        end
        stage = ST_DATA;
        load_byte(wbyte);
        return 1'b1;
    endfunction

    function automatic t_out_item bus_tick(input t_in_item it);
        t_out_item r;
        logic      tx_bit;
        r      = '0;
        tx_bit = shreg[bit_idx];
        if (phase > PH_STOP_REL) phase = PH_IDLE;
        if (phase == PH_IDLE && it.operation != OP_TICK) begin
            kind          = it.operation;
            held_reg      = it.register_address;
            bytes_left    = it.byte_count_request;
            bytes_counted = 8'd0;
            stage         = ST_DEV;
            nack_seen     = 1'b0;
            bit_idx       = BIT_MSB;
            shreg         = (it.operation == OP_PROBE) ? it.probe_address
                                                       : {dev_addr[7:1], 1'b0};
            phase_ticks   = 0;
            phase         = PH_SETUP;
            tx_bit        = shreg[7];
        end
        if (phase == PH_IDLE) begin
            r.scl_level = 1'b1;
            return r;
        end
        case (phase)
            PH_SETUP:     {r.scl_level, r.sda_pull_low} = 2'b10;
            PH_START:     {r.scl_level, r.sda_pull_low} = 2'b11;
            PH_TX_LOW:    {r.scl_level, r.sda_pull_low} = {1'b0, !tx_bit};
            PH_TX_HIGH:   {r.scl_level, r.sda_pull_low} = {1'b1, !tx_bit};
            PH_ACK_LOW:   {r.scl_level, r.sda_pull_low} = 2'b00;
            PH_ACK_HIGH:  {r.scl_level, r.sda_pull_low} = 2'b10;
            PH_RS_LOW:    {r.scl_level, r.sda_pull_low} = 2'b00;
            PH_RX_LOW:    {r.scl_level, r.sda_pull_low} = 2'b00;
            PH_RX_HIGH:   {r.scl_level, r.sda_pull_low} = 2'b10;
            PH_MACK_LOW:  {r.scl_level, r.sda_pull_low} = {1'b0, bytes_left != 8'd0};
            PH_MACK_HIGH: {r.scl_level, r.sda_pull_low} = {1'b1, bytes_left != 8'd0};
            PH_STOP_LOW:  {r.scl_level, r.sda_pull_low} = 2'b01;
            PH_STOP_HIGH: {r.scl_level, r.sda_pull_low} = 2'b11;
            default:      {r.scl_level, r.sda_pull_low} = 2'b10;
        endcase
        r.busy_res = 1'b1;
        if (phase_ticks + 1 < TICKS_PER_PHASE) begin
            phase_ticks++;
            return r;
        end
        phase_ticks = 0;
        case (phase)
            PH_SETUP:    phase = PH_START;
            PH_START:    phase = PH_TX_LOW;
            PH_TX_LOW:   phase = PH_TX_HIGH;
            PH_TX_HIGH: begin
                if (bit_idx == 3'd0) begin
                    phase = PH_ACK_LOW;
                end else begin
                    bit_idx = bit_idx - 3'd1;
                    phase   = PH_TX_LOW;
                end
            end
            PH_ACK_LOW:  phase = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
                if (it.sda_sample) begin
                    nack_seen = 1'b1;
                    phase     = PH_STOP_LOW;
                end else begin
                    case (stage)
                        ST_DEV: begin
                            if (kind == OP_PROBE) begin
                                phase = PH_STOP_LOW;
                            end else begin
                                stage = ST_REG;
                                load_byte(held_reg);
                            end
                        end
                        ST_REG: begin
                            if (kind == OP_READ) begin
                                stage   = ST_RDEV;
                                shreg   = dev_addr | 8'h01;
                                bit_idx = BIT_MSB;
                                phase   = PH_RS_LOW;
                            end else begin
                                r.data_taken = next_data_or_stop(it.write_byte);
                            end
                        end
                        ST_RDEV: begin
                            if (bytes_left == 8'd0) begin
                                phase = PH_STOP_LOW;
                            end else begin
                                stage   = ST_DATA;
                                shreg   = 8'd0;
                                bit_idx = BIT_MSB;
                                phase   = PH_RX_LOW;
                            end
                        end
                        default: begin
                            bytes_counted = bytes_counted + 8'd1;
                            bytes_left    = bytes_left - 8'd1;
                            r.data_taken  = next_data_or_stop(it.write_byte);
                        end
                    endcase
                end
            end
            PH_RS_LOW:   phase = PH_SETUP;
            PH_RX_LOW:   phase = PH_RX_HIGH;
            PH_RX_HIGH: begin
                shreg = {shreg[6:0], it.sda_sample};
                if (bit_idx == 3'd0) begin
                    r.read_byte   = shreg;
                    r.read_valid  = 1'b1;
                    bytes_counted = bytes_counted + 8'd1;
                    bytes_left    = bytes_left - 8'd1;
                    phase         = PH_MACK_LOW;
                end else begin
                    bit_idx = bit_idx - 3'd1;
                    phase   = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: phase = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
                if (bytes_left == 8'd0) begin
                    phase = PH_STOP_LOW;
                end else begin
                    shreg   = 8'd0;
                    bit_idx = BIT_MSB;
                    phase   = PH_RX_LOW;
                end
            end
            PH_STOP_LOW:  phase = PH_STOP_HIGH;
            PH_STOP_HIGH: phase = PH_STOP_REL;
            default: begin
                r.done_res   = 1'b1;
                r.ack_error  = nack_seen;
                r.bytes_done = bytes_counted;
                phase        = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, result_no, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_out_item got, input t_out_item want);
        if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.sda_pull_low !== want.sda_pull_low)
            report_mismatch("sda_pull_low", got.sda_pull_low, want.sda_pull_low);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.data_taken !== want.data_taken)
            report_mismatch("data_taken", got.data_taken, want.data_taken);
        if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
        if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
        if (got.ack_error !== want.ack_error)
            report_mismatch("ack_error", got.ack_error, want.ack_error);
        if (got.bytes_done !== want.bytes_done)
            report_mismatch("bytes_done", got.bytes_done, want.bytes_done);
    endtask

    always @(posedge i_clk) begin
        t_in_item  it;
        t_out_item got;
        if (!i_rst_n) begin
            dev_addr      = DEV_ADDR_RESET;
            phase         = PH_IDLE;
            bit_idx       = 3'd0;
            shreg         = 8'd0;
            bytes_left    = 8'd0;
            bytes_counted = 8'd0;
            held_reg      = 8'd0;
            kind          = OP_TICK;
            stage         = ST_DEV;
            nack_seen     = 1'b0;
            phase_ticks   = 0;
            bus_levels_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) dev_addr = i_cfg.device_address;
            if (i_tick.valid && i_tick.ready) begin
                it.operation          = i_tick.operation;
                it.register_address   = i_tick.register_address;
                it.byte_count_request = i_tick.byte_count_request;
                it.write_byte         = i_tick.write_byte;
                it.probe_address      = i_tick.probe_address;
                it.sda_sample         = i_tick.sda_sample;
                bus_levels_q.push_back(bus_tick(it));
            end
            if (i_res.valid && i_res.ready) begin
                got.scl_level    = i_res.scl_level;
                got.sda_pull_low = i_res.sda_pull_low;
                got.busy_res     = i_res.busy_res;
                got.data_taken   = i_res.data_taken;
                got.read_byte    = i_res.read_byte;
                got.read_valid   = i_res.read_valid;
                got.done_res     = i_res.done_res;
                got.ack_error    = i_res.ack_error;
                got.bytes_done   = i_res.bytes_done;
                if (bus_levels_q.size() == 0) begin
                    report_mismatch("transfer with nothing expected", got, 0);
                end else begin
                    check_result(got, bus_levels_q.pop_front());
                end
                result_no++;
            end
        end
        o_pending = bus_levels_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the register-access bus master.
// ----------------------------------------------------------------------------
// Commands are issued as complete bus transactions: the tick count of each
// transaction is known in advance, so the slave answer on every acknowledge
// slot is placed on purpose while all other tick fields are random. A short
// directed part covers probes, writes and reads with and without a missing
// acknowledge, zero and full byte counts and a device address change in the
// middle of a read; random transactions and device addresses follow. The
// tick sender works in bursts and the result receiver stalls on a changing
// pattern. The checker beside the block predicts and compares every result.
module testbench;
    import irm_pkg::*;

    localparam int TICKS_PER_PHASE = 1;
    localparam int NO_NACK         = 999;
    localparam int NO_RETARGET     = -1;
    localparam int TOTAL_TICKS     = 650;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   waiting_count;
    int   burst_left = 0;
    int   ticks_sent = 0;
    int   stall_count = 0;
    int   stall_mode = 0;

    irm_in_if  tick_ch();
    irm_out_if res_ch();
    irm_cfg_if cfg_ch();

    i2c_register_master_top #(
        .TICKS_PER_PHASE (TICKS_PER_PHASE)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    irm_checker #(
        .TICKS_PER_PHASE (TICKS_PER_PHASE)
    ) u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatch_count),
        .o_pending    (waiting_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (stall_count % 128 == 0) stall_mode = $urandom_range(0, 3);
        stall_count++;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom);
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (stall_count % 8 != 0);
        endcase
    end

    function automatic t_in_item random_tick();
        t_in_item it;
        it.operation          = 2'($urandom_range(0, 3));
        it.register_address   = 8'($urandom_range(0, 255));
        it.byte_count_request = 8'($urandom_range(0, 255));
        it.write_byte         = 8'($urandom_range(0, 255));
        it.probe_address      = 8'($urandom_range(0, 254));
        it.sda_sample         = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_cmd(input logic [1:0] op, input logic [7:0] count);
        t_in_item it;
        it                    = random_tick();
        it.operation          = op;
        it.byte_count_request = count;
        return it;
    endfunction

    task automatic send_tick(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        tick_ch.operation          <= it.operation;
        tick_ch.register_address   <= it.register_address;
        tick_ch.byte_count_request <= it.byte_count_request;
        tick_ch.write_byte         <= it.write_byte;
        tick_ch.probe_address      <= it.probe_address;
        tick_ch.sda_sample         <= it.sda_sample;
        tick_ch.valid              <= 1'b1;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic busy_ticks(input int n);
        repeat (n) send_tick(random_tick());
    endtask

    task automatic idle_ticks(input int n);
        t_in_item it;
        repeat (n) begin
            it           = random_tick();
            it.operation = OP_TICK;
            send_tick(it);
        end
    endtask

    task automatic ack_slot(input logic nack);
        t_in_item it;
        busy_ticks(17);
        it            = random_tick();
        it.sda_sample = nack;
        send_tick(it);
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        burst_left = 0;
        while (waiting_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_device_address(input logic [7:0] addr);
        cfg_ch.device_address <= addr;
        cfg_ch.valid          <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Ack slots are numbered from the device address byte on; a read has
    // three (device, register, device again) and a write two plus one per
    // data byte.
    task automatic run_command(input t_in_item cmd, input int nack_slot, input int retarget);
        int slots;
        case (cmd.operation)
            OP_PROBE: slots = 1;
            OP_WRITE: slots = 2 + cmd.byte_count_request;
            default:  slots = 3;
        endcase
        send_tick(cmd);
        busy_ticks(1);
        for (int s = 0; s < slots; s++) begin
            if (cmd.operation == OP_READ && s == 2) busy_ticks(3);
            ack_slot(s == nack_slot);
            if (s == nack_slot) break;
            if (s == 1 && retarget >= 0) begin
                drain();
                write_device_address(8'(retarget));
            end
        end
        if (cmd.operation == OP_READ && nack_slot >= slots)
            busy_ticks(18 * cmd.byte_count_request);
        busy_ticks(3);
    endtask

    function automatic logic [7:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 8'($urandom_range(0, 2));
        if (pick < 95) return 8'($urandom_range(3, 6));
        return 8'($urandom_range(7, 16));
    endfunction

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_in_item cmd;
        int       cmds;
        int       slots;
        int       nack;
        int       retarget;
        rst_n                      = 1'b0;
        tick_ch.valid              = 1'b0;
        tick_ch.operation          = OP_TICK;
        tick_ch.register_address   = 8'd0;
        tick_ch.byte_count_request = 8'd0;
        tick_ch.write_byte         = 8'd0;
        tick_ch.probe_address      = 8'd0;
        tick_ch.sda_sample         = 1'b0;
        res_ch.ready               = 1'b0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.device_address      = 8'd0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_tick('{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_tick('{OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'd254, 1'b1});
        cmd = make_cmd(OP_PROBE, 8'd0);
        cmd.probe_address = DEV_ADDR_RESET;
        run_command(cmd, NO_NACK, NO_RETARGET);
        cmd = make_cmd(OP_PROBE, 8'hFF);
        cmd.probe_address = 8'd254;
        run_command(cmd, 0, NO_RETARGET);
        drain();
        write_device_address(8'd0);
        cmd = make_cmd(OP_WRITE, 8'd0);
        cmd.register_address = 8'd0;
        run_command(cmd, NO_NACK, NO_RETARGET);
        cmd = make_cmd(OP_WRITE, 8'd1);
        cmd.register_address = 8'hFF;
        run_command(cmd, NO_NACK, NO_RETARGET);
        drain();
        write_device_address(DEV_ADDR_RESET);
        run_command(make_cmd(OP_WRITE, 8'd255), 3, NO_RETARGET);
        run_command(make_cmd(OP_WRITE, 8'd1), 0, NO_RETARGET);
        run_command(make_cmd(OP_WRITE, 8'd1), 1, NO_RETARGET);
        run_command(make_cmd(OP_READ, 8'd2), 2, NO_RETARGET);
        run_command(make_cmd(OP_READ, 8'd2), NO_NACK, 8'h4C);
        drain();
        write_device_address(8'd254);
        run_command(make_cmd(OP_READ, 8'd0), NO_NACK, NO_RETARGET);
        idle_ticks(2);
        drain();
        write_device_address(DEV_ADDR_RESET);

        cmds = 0;
        while (ticks_sent < TOTAL_TICKS) begin
            cmd = make_cmd(2'($urandom_range(1, 3)), random_count());
            case (cmd.operation)
                OP_PROBE: slots = 1;
                OP_WRITE: slots = 2 + cmd.byte_count_request;
                default:  slots = 3;
            endcase
            nack     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, slots - 1) : NO_NACK;
            retarget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 254) : NO_RETARGET;
            run_command(cmd, nack, retarget);
            idle_ticks($urandom_range(0, 3));
            cmds++;
            if (cmds % 6 == 0) begin
                drain();
                case ($urandom_range(0, 9))
                    0:       write_device_address(8'd0);
                    1:       write_device_address(8'd254);
                    default: write_device_address(8'($urandom_range(0, 254)));
                endcase
            end
        end
        drain();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && waiting_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
